// ===== hdl/ptsd_pkg.sv =====
`timescale 1ns / 1ps

package ptsd_pkg;

  // Coordinate width of every input field
  localparam int COORD_W = 24;
  // Width of the squared distance field
  localparam int OUT_W = 50;
  // A coordinate difference is clamped to 2**CLAMP_LOG
  localparam int CLAMP_LOG = 25;

  typedef struct packed {
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
    logic signed [COORD_W-1:0] query_z;
    logic signed [COORD_W-1:0] corner_a_x;
    logic signed [COORD_W-1:0] corner_a_y;
    logic signed [COORD_W-1:0] corner_a_z;
    logic signed [COORD_W-1:0] corner_b_x;
    logic signed [COORD_W-1:0] corner_b_y;
    logic signed [COORD_W-1:0] corner_b_z;
    logic signed [COORD_W-1:0] corner_c_x;
    logic signed [COORD_W-1:0] corner_c_y;
    logic signed [COORD_W-1:0] corner_c_z;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] squared_distance;
    logic [2:0]       closest_region;
  } out_item_t;

  typedef enum logic [2:0] {
    RGN_A  = 3'd0,
    RGN_B  = 3'd1,
    RGN_AB = 3'd2,
    RGN_C  = 3'd3,
    RGN_AC = 3'd4,
    RGN_BC = 3'd5,
    RGN_IN = 3'd6
  } region_t;

  // Per-lane status of the divider result
  typedef struct packed {
    logic [2:0] neg;
    logic [2:0] sat;
    logic [2:0] rnz;
  } div_flags_t;

endpackage

// ===== hdl/ptsd_div.sv =====
`timescale 1ns / 1ps

// Three-lane pipelined restoring divider: one quotient bit per stage,
// an overflow check stage in front. Floor-rounding info is returned as
// the remainder-nonzero flag.
module ptsd_div #(
  parameter int MW    = 134,
  parameter int D2W   = 110,
  parameter int QB    = 27,
  parameter int SIDEW = 78
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0][MW-1:0]       in_mag,
  input  logic [2:0]               in_neg,
  input  logic [D2W-1:0]           in_d2,
  input  logic [SIDEW-1:0]         in_side,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0][QB-1:0]       out_q,
  output ptsd_pkg::div_flags_t     out_flags,
  output logic [SIDEW-1:0]         out_side
);

  localparam int CPW = MW + QB;

  logic             vld_r  [QB+1];
  logic             en     [QB+1];
  logic [MW-1:0]    rem_r  [QB+1][3];
  logic [MW-1:0]    rem_nxt[QB+1][3];
  logic [QB-1:0]    q_r    [QB+1][3];
  logic [QB-1:0]    q_nxt  [QB+1][3];
  logic [2:0]       sat_r  [QB+1];
  logic [2:0]       sat_nxt;
  logic [2:0]       neg_r  [QB+1];
  logic [D2W-1:0]   d2_r   [QB+1];
  logic [SIDEW-1:0] side_r [QB+1];

  // Ready chain: a stage advances when empty or when the next one advances
  always_comb begin
    en[QB] = !vld_r[QB] || out_ready;
    for (int s = QB - 1; s >= 0; s--) begin
      en[s] = !vld_r[s] || en[s+1];
    end
  end
  assign in_ready = en[0];

  // Overflow check and one quotient bit per stage
  always_comb begin
    logic [CPW-1:0] sh;
    sh = '0;
    for (int k = 0; k < 3; k++) begin
      sat_nxt[k]    = CPW'(in_mag[k]) >= (CPW'(in_d2) << QB);
      rem_nxt[0][k] = in_mag[k];
      q_nxt[0][k]   = '0;
    end
    for (int s = 1; s <= QB; s++) begin
      for (int k = 0; k < 3; k++) begin
        sh            = CPW'(d2_r[s-1]) << (QB - s);
        rem_nxt[s][k] = rem_r[s-1][k];
        q_nxt[s][k]   = q_r[s-1][k];
        if (CPW'(rem_r[s-1][k]) >= sh) begin
          rem_nxt[s][k]        = MW'(CPW'(rem_r[s-1][k]) - sh);
          q_nxt[s][k][QB - s]  = 1'b1;
        end
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= QB; s++) vld_r[s] <= 1'b0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int s = 1; s <= QB; s++) begin
        if (en[s]) vld_r[s] <= vld_r[s-1];
      end
    end
  end

  // Stage data
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0]  <= rem_nxt[0];
      q_r[0]    <= q_nxt[0];
      sat_r[0]  <= sat_nxt;
      neg_r[0]  <= in_neg;
      d2_r[0]   <= in_d2;
      side_r[0] <= in_side;
    end
    for (int s = 1; s <= QB; s++) begin
      if (en[s]) begin
        rem_r[s]  <= rem_nxt[s];
        q_r[s]    <= q_nxt[s];
        sat_r[s]  <= sat_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        d2_r[s]   <= d2_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // Drive the result beat
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      out_q[k]         = q_r[QB][k];
      out_flags.rnz[k] = |rem_r[QB][k];
    end
    out_flags.neg = neg_r[QB];
    out_flags.sat = sat_r[QB];
  end
  assign out_valid = vld_r[QB];
  assign out_side  = side_r[QB];

endmodule

// ===== hdl/point_triangle_sq_distance.sv =====
`timescale 1ns / 1ps

// Squared distance from a query point to a triangle. The block takes one
// point/triangle beat per cycle while in_ready is high and returns one
// result beat per item, in order, through 13 front stages, a 28-stage
// divider of one overflow check plus one quotient bit per stage, and 3
// back stages. Every stage holds a valid bit and advances whenever it or
// a later stage has room, so bubbles close up behind a stalled output and
// input keeps flowing until the pipeline is full. The closest region
// follows the vertex, edge and interior tests in the order A, B, AB, C,
// AC, BC, with the interior as the fallback.
module point_triangle_sq_distance (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ptsd_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ptsd_pkg::out_item_t   out_data
);

  localparam int CW    = ptsd_pkg::COORD_W;
  localparam int CL    = ptsd_pkg::CLAMP_LOG;
  localparam int OW    = ptsd_pkg::OUT_W;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  localparam int DTW   = PW + 2;
  localparam int HK    = (DTW + 1) / 2;
  localparam int HW    = DTW - HK;
  localparam int VPW   = 2 * DTW;
  localparam int VW    = VPW + 1;
  localparam int NK    = (VW + 3) / 4;
  localparam int EPW   = DW + NK + 1;
  localparam int SW1   = DW + VW;
  localparam int NW    = SW1 + 1;
  localparam int DENW  = VW + 2;
  localparam int NW2   = NW + 1;
  localparam int DENW2 = DENW + 1;
  localparam int MW    = NW2 + 2;
  localparam int D2W   = DENW2 + 1;
  localparam int QB    = ((CW > CL) ? CW : CL) + 2;
  localparam int TW    = ((DW > QB + 2) ? DW : QB + 2) + 1;
  localparam int MGW   = CL + 1;
  localparam int SQW   = 2 * MGW;
  localparam int SUMW  = SQW + 2;
  localparam int NPRE  = 13;
  localparam int SIDEW = 3 * DW + 3;

  localparam logic [TW-1:0]   CLAMP_T = TW'(1) << CL;
  localparam logic [SUMW-1:0] MAX_OUT = SUMW'({OW{1'b1}});

  // Edge and offset vector slots
  localparam int IAB = 0;
  localparam int IAC = 1;
  localparam int IBC = 2;
  localparam int IAP = 3;
  localparam int IBP = 4;
  localparam int ICP = 5;

  // Dot product operands: d1..d6
  localparam int DOT_L [6] = '{IAB, IAC, IAB, IAC, IAB, IAC};
  localparam int DOT_R [6] = '{IAP, IAP, IBP, IBP, ICP, ICP};
  // Products of dot values for the barycentric terms
  localparam int VP_L [6] = '{0, 2, 4, 0, 2, 4};
  localparam int VP_R [6] = '{3, 1, 1, 5, 5, 3};

  // ---------------- front pipeline control ----------------
  logic vld_r [NPRE];
  logic en    [NPRE];
  logic div_in_ready;

  always_comb begin
    en[NPRE-1] = !vld_r[NPRE-1] || div_in_ready;
    for (int s = NPRE - 2; s >= 0; s--) begin
      en[s] = !vld_r[s] || en[s+1];
    end
  end
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NPRE; s++) vld_r[s] <= 1'b0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int s = 1; s < NPRE; s++) begin
        if (en[s]) vld_r[s] <= vld_r[s-1];
      end
    end
  end

  // ---------------- front pipeline data ----------------
  ptsd_pkg::in_item_t in_r;
  logic signed [CW-1:0] pq [3];
  logic signed [CW-1:0] pa [3];
  logic signed [CW-1:0] pb [3];
  logic signed [CW-1:0] pc [3];

  logic signed [DW-1:0]   vec_nxt [6][3];
  logic signed [DW-1:0]   vec_r   [1:6][6][3];
  logic signed [PW-1:0]   pr_nxt  [6][3];
  logic signed [PW-1:0]   pr_r    [6][3];
  logic signed [DTW-1:0]  d_nxt   [6];
  logic signed [DTW-1:0]  dd_r    [3:6][6];
  logic signed [2*HW-1:0] hh_nxt [6];
  logic signed [2*HW-1:0] hh_r   [6];
  logic signed [HW+HK:0]  hl_nxt [6];
  logic signed [HW+HK:0]  hl_r   [6];
  logic signed [HW+HK:0]  lh_nxt [6];
  logic signed [HW+HK:0]  lh_r   [6];
  logic signed [2*HK+1:0] ll_nxt [6];
  logic signed [2*HK+1:0] ll_r   [6];
  logic signed [VPW-1:0]  vp_nxt [6];
  logic signed [VPW-1:0]  vp_r   [6];
  logic signed [VW-1:0]   va_nxt, vb_nxt, vc_nxt;
  logic signed [VW-1:0]   va_r, vb_r, vc_r;

  ptsd_pkg::region_t      rgn_nxt;
  ptsd_pkg::region_t      rgn_r  [7:12];
  logic signed [DW-1:0]   base_nxt [3];
  logic signed [DW-1:0]   base_r [7:12][3];
  logic signed [DW-1:0]   e1_nxt [3];
  logic signed [DW-1:0]   e2_nxt [3];
  logic signed [DW-1:0]   e1_r   [3];
  logic signed [DW-1:0]   e2_r   [3];
  logic signed [VW-1:0]   n1_nxt, n2_nxt;
  logic signed [VW-1:0]   n1_r, n2_r;
  logic signed [DENW-1:0] den_nxt;
  logic signed [DENW-1:0] dn_r [7:10];

  logic signed [EPW-1:0]   pn_nxt [3][2][4];
  logic signed [EPW-1:0]   pn_r   [3][2][4];
  logic signed [SW1-1:0]   ms_nxt [3][2];
  logic signed [SW1-1:0]   ms_r   [3][2];
  logic signed [NW-1:0]    num_nxt [3];
  logic signed [NW-1:0]    num_r   [3];
  logic signed [NW2-1:0]   num2_nxt [3];
  logic signed [NW2-1:0]   num2_r   [3];
  logic signed [DENW2-1:0] den2_nxt;
  logic signed [DENW2-1:0] den2_r;
  logic [2:0][MW-1:0]      mag_nxt;
  logic [2:0][MW-1:0]      mag_r;
  logic [2:0]              neg_nxt;
  logic [2:0]              neg_r;
  logic [D2W-1:0]          d2_nxt;
  logic [D2W-1:0]          d2_r;

  // Unpack the item coordinates
  always_comb begin
    pq[0] = in_r.query_x;    pq[1] = in_r.query_y;    pq[2] = in_r.query_z;
    pa[0] = in_r.corner_a_x; pa[1] = in_r.corner_a_y; pa[2] = in_r.corner_a_z;
    pb[0] = in_r.corner_b_x; pb[1] = in_r.corner_b_y; pb[2] = in_r.corner_b_z;
    pc[0] = in_r.corner_c_x; pc[1] = in_r.corner_c_y; pc[2] = in_r.corner_c_z;
  end

  // Stage 1: edge and offset vectors
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vec_nxt[IAB][k] = DW'(pb[k]) - DW'(pa[k]);
      vec_nxt[IAC][k] = DW'(pc[k]) - DW'(pa[k]);
      vec_nxt[IBC][k] = DW'(pc[k]) - DW'(pb[k]);
      vec_nxt[IAP][k] = DW'(pq[k]) - DW'(pa[k]);
      vec_nxt[IBP][k] = DW'(pq[k]) - DW'(pb[k]);
      vec_nxt[ICP][k] = DW'(pq[k]) - DW'(pc[k]);
    end
  end

  // Stages 2-3: dot products, multiply then sum
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      for (int k = 0; k < 3; k++) begin
        pr_nxt[j][k] = PW'(vec_r[1][DOT_L[j]][k]) * PW'(vec_r[1][DOT_R[j]][k]);
      end
      d_nxt[j] = DTW'(pr_r[j][0]) + DTW'(pr_r[j][1]) + DTW'(pr_r[j][2]);
    end
  end

  // Stage 4: split dot-by-dot products into half-width partials
  always_comb begin
    logic signed [HW-1:0] xh, yh;
    logic signed [HK:0]   xl, yl;
    xh = '0; yh = '0; xl = '0; yl = '0;
    for (int j = 0; j < 6; j++) begin
      xh = $signed(dd_r[3][VP_L[j]][DTW-1:HK]);
      yh = $signed(dd_r[3][VP_R[j]][DTW-1:HK]);
      xl = $signed({1'b0, dd_r[3][VP_L[j]][HK-1:0]});
      yl = $signed({1'b0, dd_r[3][VP_R[j]][HK-1:0]});
      hh_nxt[j] = xh * yh;
      hl_nxt[j] = xh * yl;
      lh_nxt[j] = xl * yh;
      ll_nxt[j] = xl * yl;
    end
  end

  // Stages 5-6: combine partials, then form va, vb, vc
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      vp_nxt[j] = (VPW'(hh_r[j]) <<< (2 * HK)) + (VPW'(hl_r[j]) <<< HK)
                + (VPW'(lh_r[j]) <<< HK) + VPW'(ll_r[j]);
    end
    vc_nxt = VW'(vp_r[0]) - VW'(vp_r[1]);
    vb_nxt = VW'(vp_r[2]) - VW'(vp_r[3]);
    va_nxt = VW'(vp_r[4]) - VW'(vp_r[5]);
  end

  // Stage 7: pick the region and the weight ratio for it
  always_comb begin
    logic signed [DTW-1:0] d1, d2, d3, d4, d5, d6;
    logic signed [DTW:0]   e43, e56;
    logic                  t_a, t_b, t_ab, t_c, t_ac, t_bc;
    int                    bsel;
    d1 = dd_r[6][0]; d2 = dd_r[6][1]; d3 = dd_r[6][2];
    d4 = dd_r[6][3]; d5 = dd_r[6][4]; d6 = dd_r[6][5];
    e43 = (DTW+1)'(d4) - (DTW+1)'(d3);
    e56 = (DTW+1)'(d5) - (DTW+1)'(d6);
    t_a  = (d1 <= 0) && (d2 <= 0);
    t_b  = (d3 >= 0) && (e43 <= 0);
    t_ab = (vc_r <= 0) && (d1 >= 0) && (d3 <= 0);
    t_c  = (d6 >= 0) && (e56 <= 0);
    t_ac = (vb_r <= 0) && (d2 >= 0) && (d6 <= 0);
    t_bc = (va_r <= 0) && (e43 >= 0) && (e56 >= 0);

    rgn_nxt = ptsd_pkg::RGN_IN;
    bsel    = IAP;
    for (int k = 0; k < 3; k++) begin
      e1_nxt[k] = vec_r[6][IAB][k];
      e2_nxt[k] = vec_r[6][IAC][k];
    end
    n1_nxt  = vb_r;
    n2_nxt  = vc_r;
    den_nxt = DENW'(va_r) + DENW'(vb_r) + DENW'(vc_r);

    if (t_a || t_b || t_c) begin
      // Vertex A or B first, then edge AB, then vertex C
      if (t_a) begin
        rgn_nxt = ptsd_pkg::RGN_A;
        bsel    = IAP;
      end else if (t_b) begin
        rgn_nxt = ptsd_pkg::RGN_B;
        bsel    = IBP;
      end else if (t_ab) begin
        rgn_nxt = ptsd_pkg::RGN_AB;
        bsel    = IAP;
      end else begin
        rgn_nxt = ptsd_pkg::RGN_C;
        bsel    = ICP;
      end
    end
    if (!t_a && !t_b && t_ab) begin
      rgn_nxt = ptsd_pkg::RGN_AB;
      bsel    = IAP;
    end
    if (!t_a && !t_b && !t_ab && !t_c && t_ac) begin
      rgn_nxt = ptsd_pkg::RGN_AC;
      bsel    = IAP;
    end
    if (!t_a && !t_b && !t_ab && !t_c && !t_ac && t_bc) begin
      rgn_nxt = ptsd_pkg::RGN_BC;
      bsel    = IBP;
    end

    case (rgn_nxt)
      ptsd_pkg::RGN_AB: begin
        for (int k = 0; k < 3; k++) e1_nxt[k] = vec_r[6][IAB][k];
        n1_nxt  = VW'(d1);
        n2_nxt  = '0;
        den_nxt = DENW'(d1) - DENW'(d3);
      end
      ptsd_pkg::RGN_AC: begin
        for (int k = 0; k < 3; k++) e1_nxt[k] = vec_r[6][IAC][k];
        n1_nxt  = VW'(d2);
        n2_nxt  = '0;
        den_nxt = DENW'(d2) - DENW'(d6);
      end
      ptsd_pkg::RGN_BC: begin
        for (int k = 0; k < 3; k++) e1_nxt[k] = vec_r[6][IBC][k];
        n1_nxt  = VW'(e43);
        n2_nxt  = '0;
        den_nxt = DENW'(e43) + DENW'(e56);
      end
      ptsd_pkg::RGN_IN: begin
        n1_nxt = vb_r;
        n2_nxt = vc_r;
      end
      default: begin
        // Vertex regions: no offset
        n1_nxt  = '0;
        n2_nxt  = '0;
        den_nxt = DENW'(1);
      end
    endcase

    // Zero divisor: the closest point is the start corner
    if (den_nxt == 0) begin
      n1_nxt  = '0;
      n2_nxt  = '0;
      den_nxt = DENW'(1);
    end

    for (int k = 0; k < 3; k++) base_nxt[k] = vec_r[6][bsel][k];
  end

  // Stage 8: numerator partials, weight split into four chunks
  always_comb begin
    logic signed [NK:0]   ch [2][4];
    logic signed [VW-1:0] nv [2];
    nv[0] = n1_r;
    nv[1] = n2_r;
    for (int m = 0; m < 2; m++) begin
      for (int c = 0; c < 3; c++) ch[m][c] = $signed({1'b0, nv[m][c*NK +: NK]});
      ch[m][3] = (NK+1)'($signed(nv[m][VW-1:3*NK]));
    end
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 4; c++) begin
        pn_nxt[k][0][c] = e1_r[k] * ch[0][c];
        pn_nxt[k][1][c] = e2_r[k] * ch[1][c];
      end
    end
  end

  // Stages 9-12: numerator sums, sign fix, doubled rounding terms
  always_comb begin
    logic signed [SW1-1:0] acc;
    logic signed [MW-1:0]  mm;
    acc = '0;
    mm  = '0;
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 2; m++) begin
        acc = '0;
        for (int c = 0; c < 4; c++) acc = acc + (SW1'(pn_r[k][m][c]) <<< (c * NK));
        ms_nxt[k][m] = acc;
      end
      num_nxt[k] = NW'(ms_r[k][0]) + NW'(ms_r[k][1]);
      if (dn_r[10] < 0) begin
        num2_nxt[k] = -NW2'(num_r[k]);
      end else begin
        num2_nxt[k] = NW2'(num_r[k]);
      end
      mm          = (MW'(num2_r[k]) <<< 1) + MW'(den2_r);
      neg_nxt[k]  = mm[MW-1];
      mag_nxt[k]  = mm[MW-1] ? MW'(-mm) : MW'(mm);
    end
    den2_nxt = (dn_r[10] < 0) ? -DENW2'(dn_r[10]) : DENW2'(dn_r[10]);
    d2_nxt   = D2W'(den2_r) << 1;
  end

  // Front data registers
  always_ff @(posedge clk) begin
    if (en[0]) in_r <= in_data;
    if (en[1]) vec_r[1] <= vec_nxt;
    for (int s = 2; s <= 6; s++) begin
      if (en[s]) vec_r[s] <= vec_r[s-1];
    end
    if (en[2]) pr_r <= pr_nxt;
    if (en[3]) dd_r[3] <= d_nxt;
    for (int s = 4; s <= 6; s++) begin
      if (en[s]) dd_r[s] <= dd_r[s-1];
    end
    if (en[4]) begin
      hh_r <= hh_nxt;
      hl_r <= hl_nxt;
      lh_r <= lh_nxt;
      ll_r <= ll_nxt;
    end
    if (en[5]) vp_r <= vp_nxt;
    if (en[6]) begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
      vc_r <= vc_nxt;
    end
    if (en[7]) begin
      rgn_r[7]  <= rgn_nxt;
      base_r[7] <= base_nxt;
      e1_r      <= e1_nxt;
      e2_r      <= e2_nxt;
      n1_r      <= n1_nxt;
      n2_r      <= n2_nxt;
      dn_r[7]   <= den_nxt;
    end
    for (int s = 8; s <= 12; s++) begin
      if (en[s]) begin
        rgn_r[s]  <= rgn_r[s-1];
        base_r[s] <= base_r[s-1];
      end
    end
    for (int s = 8; s <= 10; s++) begin
      if (en[s]) dn_r[s] <= dn_r[s-1];
    end
    if (en[8]) pn_r <= pn_nxt;
    if (en[9]) ms_r <= ms_nxt;
    if (en[10]) num_r <= num_nxt;
    if (en[11]) begin
      num2_r <= num2_nxt;
      den2_r <= den2_nxt;
    end
    if (en[12]) begin
      mag_r <= mag_nxt;
      neg_r <= neg_nxt;
      d2_r  <= d2_nxt;
    end
  end

  // ---------------- divider ----------------
  logic                 div_out_valid;
  logic                 div_out_ready;
  logic [2:0][QB-1:0]   div_q;
  ptsd_pkg::div_flags_t div_flags;
  logic [SIDEW-1:0]     div_side_in;
  logic [SIDEW-1:0]     div_side;

  assign div_side_in = {rgn_r[12], base_r[12][2], base_r[12][1], base_r[12][0]};

  ptsd_div #(
    .MW    (MW),
    .D2W   (D2W),
    .QB    (QB),
    .SIDEW (SIDEW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_r[NPRE-1]),
    .in_ready  (div_in_ready),
    .in_mag    (mag_r),
    .in_neg    (neg_r),
    .in_d2     (d2_r),
    .in_side   (div_side_in),
    .out_valid (div_out_valid),
    .out_ready (div_out_ready),
    .out_q     (div_q),
    .out_flags (div_flags),
    .out_side  (div_side)
  );

  // ---------------- back pipeline ----------------
  logic                pv_r [3];
  logic                pen  [3];
  logic [MGW-1:0]      mg_nxt [3];
  logic [MGW-1:0]      mg_r   [3];
  logic [SQW-1:0]      sq_nxt [3];
  logic [SQW-1:0]      sq_r   [3];
  logic [2:0]          prg_r  [2];
  ptsd_pkg::out_item_t res_nxt;
  ptsd_pkg::out_item_t res_r;

  always_comb begin
    pen[2] = !pv_r[2] || out_ready;
    pen[1] = !pv_r[1] || pen[2];
    pen[0] = !pv_r[0] || pen[1];
  end
  assign div_out_ready = pen[0];

  // Rounded offset, distance per axis with clamp, squares and sum
  always_comb begin
    logic signed [QB+1:0] qx, tv;
    logic signed [TW-1:0] df;
    logic [TW-1:0]        ad;
    logic [SUMW-1:0]      sum;
    qx = '0; tv = '0; df = '0; ad = '0;
    for (int k = 0; k < 3; k++) begin
      qx = $signed({2'b00, div_q[k]});
      tv = div_flags.neg[k] ? -(qx + $signed({{(QB+1){1'b0}}, div_flags.rnz[k]})) : qx;
      df = TW'($signed(div_side[k*DW +: DW])) - TW'(tv);
      ad = df[TW-1] ? TW'(-df) : TW'(df);
      if (div_flags.sat[k] || (ad > CLAMP_T)) begin
        mg_nxt[k] = MGW'(CLAMP_T);
      end else begin
        mg_nxt[k] = ad[MGW-1:0];
      end
      sq_nxt[k] = SQW'(mg_r[k]) * SQW'(mg_r[k]);
    end
    sum = SUMW'(sq_r[0]) + SUMW'(sq_r[1]) + SUMW'(sq_r[2]);
    res_nxt.squared_distance = (sum > MAX_OUT) ? {OW{1'b1}} : sum[OW-1:0];
    res_nxt.closest_region   = prg_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 3; s++) pv_r[s] <= 1'b0;
    end else begin
      if (pen[0]) pv_r[0] <= div_out_valid;
      if (pen[1]) pv_r[1] <= pv_r[0];
      if (pen[2]) pv_r[2] <= pv_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (pen[0]) begin
      mg_r     <= mg_nxt;
      prg_r[0] <= div_side[SIDEW-1 -: 3];
    end
    if (pen[1]) begin
      sq_r     <= sq_nxt;
      prg_r[1] <= prg_r[0];
    end
    if (pen[2]) res_r <= res_nxt;
  end

  assign out_valid = pv_r[2];
  assign out_data  = res_r;

endmodule

// ===== hdl/ptsd_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks for the triangle distance block
module ptsd_port_checks (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ptsd_pkg::out_item_t out_data
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result beat changed while stalled");

  // Region code stays within the defined set
  a_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.closest_region <= ptsd_pkg::RGN_IN))
    else $error("region code out of range");

  // Drop every beat in flight on reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An output that can move never blocks input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input blocked while output drains");

endmodule

bind point_triangle_sq_distance ptsd_port_checks u_ptsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
